### rtl/core/cbim_pkg.sv
// ============================================================================
// cbim_pkg: shared types and constants for the cartridge bank/IRQ mapper
// Write decode addresses, bank update target codes and the control structs
// passed between the decoder, the IRQ counter and the top level.
// ============================================================================
package cbim_pkg;

  // Field widths
  localparam int ADDR_W   = 16;
  localparam int DATA_W   = 8;
  localparam int CYC_W    = 7;
  localparam int TARGET_W = 4;

  // Address decode mask and decoded register addresses
  localparam logic [ADDR_W-1:0] ADDR_MASK     = 16'hF003;
  localparam logic [ADDR_W-1:0] REG_PRG16K    = 16'h8000;
  localparam logic [ADDR_W-1:0] REG_MIRROR    = 16'hB003;
  localparam logic [ADDR_W-1:0] REG_PRG8K     = 16'hC000;
  localparam logic [ADDR_W-1:0] REG_CHR0      = 16'hD000;
  localparam logic [ADDR_W-1:0] REG_CHR1      = 16'hD001;
  localparam logic [ADDR_W-1:0] REG_CHR2      = 16'hD002;
  localparam logic [ADDR_W-1:0] REG_CHR3      = 16'hD003;
  localparam logic [ADDR_W-1:0] REG_CHR4      = 16'hE000;
  localparam logic [ADDR_W-1:0] REG_CHR5      = 16'hE001;
  localparam logic [ADDR_W-1:0] REG_CHR6      = 16'hE002;
  localparam logic [ADDR_W-1:0] REG_CHR7      = 16'hE003;
  localparam logic [ADDR_W-1:0] REG_IRQ_LATCH = 16'hF000;
  localparam logic [ADDR_W-1:0] REG_IRQ_CTRL  = 16'hF001;
  localparam logic [ADDR_W-1:0] REG_IRQ_ACK   = 16'hF002;

  // Bank update target codes
  localparam logic [TARGET_W-1:0] TGT_PRG16K = 4'd0;
  localparam logic [TARGET_W-1:0] TGT_PRG8K  = 4'd1;
  localparam logic [TARGET_W-1:0] TGT_CHR0   = 4'd2;
  localparam logic [TARGET_W-1:0] TGT_CHR4   = 4'd6;
  localparam logic [TARGET_W-1:0] TGT_MIRROR = 4'd10;

  // Counter overflow value
  localparam logic [DATA_W-1:0] COUNT_MAX = 8'hFF;

  // Decoder result for one bus write
  typedef struct packed {
    logic                upd_valid;
    logic [TARGET_W-1:0] upd_target;
    logic [DATA_W-1:0]   upd_value;
    logic                reload_wr;    // IRQ latch write
    logic                enable_wr;    // IRQ control write
    logic                enable_copy;  // IRQ acknowledge write
  } cbim_dec_t;

  // Control item for the IRQ counter
  typedef struct packed {
    logic              go;           // item is processed this cycle
    logic              tick;         // elapsed cycle tick
    logic [CYC_W-1:0]  cycles;
    logic              reload_wr;
    logic              enable_wr;
    logic              enable_copy;
    logic [DATA_W-1:0] data;
  } cbim_ctl_t;

endpackage

### rtl/core/cbim_decode.sv
// ============================================================================
// cbim_decode: CPU write address decoder
// Masks the address with 0xF003 and reports bank/mirroring updates and
// IRQ register strobes. Purely combinational.
// ============================================================================
module cbim_decode
  import cbim_pkg::*;
(
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] address,
  input  logic [DATA_W-1:0] data,
  output cbim_dec_t         dec
);

  logic [ADDR_W-1:0] reg_sel;

  assign reg_sel = address & ADDR_MASK;

  // Register decode; non-update results carry zero target and value
  always_comb begin
    dec = '0;
    if (wr_en) begin
      case (reg_sel)
        REG_PRG16K: begin
          dec.upd_valid  = 1'b1;
          dec.upd_target = TGT_PRG16K;
          dec.upd_value  = data;
        end
        REG_MIRROR: begin
          dec.upd_valid  = 1'b1;
          dec.upd_target = TGT_MIRROR;
          dec.upd_value  = {6'd0, data[4:3]};
        end
        REG_PRG8K: begin
          dec.upd_valid  = 1'b1;
          dec.upd_target = TGT_PRG8K;
          dec.upd_value  = data;
        end
        REG_CHR0, REG_CHR1, REG_CHR2, REG_CHR3: begin
          dec.upd_valid  = 1'b1;
          dec.upd_target = TGT_CHR0 + {2'd0, reg_sel[1:0]};
          dec.upd_value  = data;
        end
        REG_CHR4, REG_CHR5, REG_CHR6, REG_CHR7: begin
          dec.upd_valid  = 1'b1;
          dec.upd_target = TGT_CHR4 + {2'd0, reg_sel[1:0]};
          dec.upd_value  = data;
        end
        REG_IRQ_LATCH: dec.reload_wr   = 1'b1;
        REG_IRQ_CTRL:  dec.enable_wr   = 1'b1;
        REG_IRQ_ACK:   dec.enable_copy = 1'b1;
        default: ;  // audio and unmapped addresses
      endcase
    end
  end

endmodule

### rtl/core/cbim_irq_counter.sv
// ============================================================================
// cbim_irq_counter: IRQ prescaler, up-counter and interrupt level
// Holds latch, enable bits, prescaler and counter; updates them once per
// processed item and exposes the IRQ level that results.
// ============================================================================
module cbim_irq_counter
  import cbim_pkg::*;
#(
  parameter int PRESCALE_PERIOD = 114
) (
  input  logic      clk,
  input  logic      rst,
  input  cbim_ctl_t ctl,
  output logic      irq_next
);

  localparam int CW = (PRESCALE_PERIOD > 2) ? $clog2(PRESCALE_PERIOD) : 1;
  localparam logic [CYC_W-1:0] CYC_LIMIT = CYC_W'(PRESCALE_PERIOD - 1);
  localparam logic [CW:0]      PERIOD_EXT = (CW + 1)'(PRESCALE_PERIOD);

  logic [DATA_W-1:0] reload_value, reload_value_next;
  logic [DATA_W-1:0] up_counter, up_counter_next;
  logic [1:0]        enable_bits, enable_bits_next;
  logic [CW-1:0]     prescale_count, prescale_count_next;
  logic              irq_level, irq_level_next;

  logic [CYC_W-1:0]  cyc_sat;
  logic [CW:0]       pre_sum;
  logic              overflow;

  // Saturate cycle count and add to prescaler
  assign cyc_sat  = (ctl.cycles > CYC_LIMIT) ? CYC_LIMIT : ctl.cycles;
  assign pre_sum  = {1'b0, prescale_count} + {1'b0, CW'(cyc_sat)};
  assign overflow = (pre_sum >= PERIOD_EXT);

  // Next state for one item
  always_comb begin
    reload_value_next   = reload_value;
    up_counter_next     = up_counter;
    enable_bits_next    = enable_bits;
    prescale_count_next = prescale_count;
    irq_level_next      = irq_level;
    if (ctl.tick) begin
      if (enable_bits[1]) begin
        if (overflow) begin
          prescale_count_next = CW'(pre_sum - PERIOD_EXT);
          if (up_counter == COUNT_MAX) begin
            up_counter_next = reload_value;
            irq_level_next  = 1'b1;
          end else begin
            up_counter_next = up_counter + 8'd1;
          end
        end else begin
          prescale_count_next = CW'(pre_sum);
        end
      end
    end else if (ctl.reload_wr) begin
      reload_value_next = ctl.data;
    end else if (ctl.enable_wr) begin
      enable_bits_next = ctl.data[1:0];
      if (ctl.data[1]) begin
        up_counter_next     = reload_value;
        prescale_count_next = '0;
      end
      irq_level_next = 1'b0;
    end else if (ctl.enable_copy) begin
      enable_bits_next = {enable_bits[0], enable_bits[0]};
      irq_level_next   = 1'b0;
    end
  end

  assign irq_next = irq_level_next;

  // State registers, advanced only when an item is processed
  always_ff @(posedge clk) begin
    if (rst) begin
      reload_value   <= '0;
      up_counter     <= '0;
      enable_bits    <= '0;
      prescale_count <= '0;
      irq_level      <= 1'b0;
    end else if (ctl.go) begin
      reload_value   <= reload_value_next;
      up_counter     <= up_counter_next;
      enable_bits    <= enable_bits_next;
      prescale_count <= prescale_count_next;
      irq_level      <= irq_level_next;
    end
  end

endmodule

### rtl/core/cartridge_bank_irq_mapper.sv
// ============================================================================
// cartridge_bank_irq_mapper: bank switching and IRQ counter cartridge mapper
// Pipeline: an accepted input is held in the input register, and its result is
// then registered in the result register and held there until m_tready takes it.
// Throughput: one item per cycle while m_tready is high; the single-pass decode
// and counter update between the two registers set that rate.
// Reset: synchronous rst clears both stages and all IRQ counter state.
// ============================================================================
module cartridge_bank_irq_mapper
  import cbim_pkg::*;
#(
  parameter int PRESCALE_PERIOD = 114
) (
  input  logic        clk,
  input  logic        rst,
  // input items
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // address[15:0], data[23:16], cycles[30:24], 0
  input  logic        s_tuser,   // mode (0 bus write, 1 tick)
  // result items
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // irq_line[0], update_target[4:1],
                                 // update_value[12:5], 0
  output logic        m_tuser    // update_valid
);

  // Input register
  logic              in_valid;
  logic              in_mode;
  logic [ADDR_W-1:0] in_address;
  logic [DATA_W-1:0] in_data;
  logic [CYC_W-1:0]  in_cycles;

  // Result register
  logic                out_valid;
  logic                out_irq;
  logic                out_upd_valid;
  logic [TARGET_W-1:0] out_target;
  logic [DATA_W-1:0]   out_value;

  logic      advance;
  cbim_dec_t dec;
  cbim_ctl_t ctl;
  logic      irq_next;

  // Pipeline flow control
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_mode    <= s_tuser;
      in_address <= s_tdata[15:0];
      in_data    <= s_tdata[23:16];
      in_cycles  <= s_tdata[30:24];
    end
  end

  // Write decode
  cbim_decode u_decode (
    .wr_en   (!in_mode),
    .address (in_address),
    .data    (in_data),
    .dec     (dec)
  );

  // Counter control item
  always_comb begin
    ctl.go          = advance;
    ctl.tick        = in_mode;
    ctl.cycles      = in_cycles;
    ctl.reload_wr   = dec.reload_wr;
    ctl.enable_wr   = dec.enable_wr;
    ctl.enable_copy = dec.enable_copy;
    ctl.data        = in_data;
  end

  cbim_irq_counter #(
    .PRESCALE_PERIOD (PRESCALE_PERIOD)
  ) u_irq_counter (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .irq_next (irq_next)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_irq       <= irq_next;
      out_upd_valid <= dec.upd_valid;
      out_target    <= dec.upd_target;
      out_value     <= dec.upd_value;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_upd_valid;
  assign m_tdata  = {3'd0, out_value, out_target, out_irq};

  // Checks
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  a_no_update_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tdata[12:1] == 12'd0))
    else $error("non-update result carries target or value");

  a_target_range: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata[4:1] <= TGT_MIRROR))
    else $error("update target out of range");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    (!m_tvalid || m_tready) |-> s_tready)
    else $error("input stalled with free result slot");

endmodule
